// ----- hdl/smdf_pkg.sv -----
// ----------------------------------------------------------------------------
// smdf_pkg
// Shared constants and types for the sliding median distance filter.
// ----------------------------------------------------------------------------
package smdf_pkg;

	// distance field width and the value the window and last distance reset to
	localparam int unsigned DIST_W = 13;
	localparam logic [DIST_W-1:0] RESET_DISTANCE = 13'd8190;

	// default window depth
	localparam int unsigned WINDOW_DEF = 5;

	// median sequencer states
	typedef enum logic [1:0] {
		MED_IDLE,
		MED_LOAD,
		MED_SCAN,
		MED_DONE
	} med_state_t;

	// control from the top level to the median sequencer
	typedef struct packed {
		logic start;   // window update done, begin a selection pass
		logic ack;     // result taken into the output register
	} med_ctrl_t;

endpackage

// ----- hdl/smdf_window.sv -----
// ----------------------------------------------------------------------------
// smdf_window
// Circular sample window, write position and last accepted distance.
// ----------------------------------------------------------------------------
module smdf_window #(
	parameter int unsigned WINDOW = smdf_pkg::WINDOW_DEF,
	localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [smdf_pkg::DIST_W-1:0] wr_data,
	input  logic [IDX_W-1:0]            rd_addr,
	output logic [smdf_pkg::DIST_W-1:0] rd_data,
	output logic [smdf_pkg::DIST_W-1:0] latest
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

	logic [smdf_pkg::DIST_W-1:0] win_q [WINDOW];
	logic [IDX_W-1:0]            pos_q;
	logic [smdf_pkg::DIST_W-1:0] latest_q;

	// window entries, overwrite oldest on each accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= smdf_pkg::RESET_DISTANCE;
			end
			pos_q    <= '0;
			latest_q <= smdf_pkg::RESET_DISTANCE;
		end else if (wr_en) begin
			win_q[pos_q] <= wr_data;
			latest_q     <= wr_data;
			if (pos_q == LAST_IDX) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// single read port for the median unit
	assign rd_data = win_q[rd_addr];
	assign latest  = latest_q;

endmodule

// ----- hdl/smdf_median.sv -----
// ----------------------------------------------------------------------------
// smdf_median
// Selection sequencer: one shared compare unit ranks each candidate entry
// against the whole window until the entry at sorted index WINDOW/2 is found.
// ----------------------------------------------------------------------------
module smdf_median #(
	parameter int unsigned WINDOW = smdf_pkg::WINDOW_DEF,
	localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
	localparam int unsigned CNT_W = $clog2(WINDOW + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  smdf_pkg::med_ctrl_t         ctrl,
	output logic [IDX_W-1:0]            rd_addr,
	input  logic [smdf_pkg::DIST_W-1:0] rd_data,
	output logic                        done,
	output logic [smdf_pkg::DIST_W-1:0] median
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0] MED_RANK = CNT_W'(WINDOW / 2);

	smdf_pkg::med_state_t state_q, state_d;

	logic [IDX_W-1:0]            cand_idx_q;
	logic [IDX_W-1:0]            scan_idx_q;
	logic [smdf_pkg::DIST_W-1:0] cand_q;
	logic [CNT_W-1:0]            lt_cnt_q;
	logic [CNT_W-1:0]            le_cnt_q;
	logic [smdf_pkg::DIST_W-1:0] median_q;

	logic             lt_hit;
	logic             le_hit;
	logic [CNT_W-1:0] lt_cnt_nxt;
	logic [CNT_W-1:0] le_cnt_nxt;
	logic             found;
	logic             scan_end;

	// shared compare unit and rank counters
	assign rd_addr    = (state_q == smdf_pkg::MED_LOAD) ? cand_idx_q : scan_idx_q;
	assign lt_hit     = rd_data < cand_q;
	assign le_hit     = rd_data <= cand_q;
	assign lt_cnt_nxt = lt_cnt_q + CNT_W'(lt_hit);
	assign le_cnt_nxt = le_cnt_q + CNT_W'(le_hit);
	// candidate covers sorted positions lt .. le-1
	assign found      = (lt_cnt_nxt <= MED_RANK) && (MED_RANK < le_cnt_nxt);
	assign scan_end   = (scan_idx_q == LAST_IDX);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smdf_pkg::MED_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			smdf_pkg::MED_IDLE: begin
				if (ctrl.start) begin
					state_d = smdf_pkg::MED_LOAD;
				end
			end
			smdf_pkg::MED_LOAD: begin
				state_d = smdf_pkg::MED_SCAN;
			end
			smdf_pkg::MED_SCAN: begin
				if (scan_end) begin
					state_d = found ? smdf_pkg::MED_DONE : smdf_pkg::MED_LOAD;
				end
			end
			smdf_pkg::MED_DONE: begin
				done = 1'b1;
				if (ctrl.ack) begin
					state_d = smdf_pkg::MED_IDLE;
				end
			end
			default: begin
				state_d = smdf_pkg::MED_IDLE;
			end
		endcase
	end

	// datapath: candidate, scan index, counters, result
	always_ff @(posedge clk) begin
		case (state_q)
			smdf_pkg::MED_IDLE: begin
				cand_idx_q <= '0;
			end
			smdf_pkg::MED_LOAD: begin
				cand_q     <= rd_data;
				scan_idx_q <= '0;
				lt_cnt_q   <= '0;
				le_cnt_q   <= '0;
			end
			smdf_pkg::MED_SCAN: begin
				lt_cnt_q   <= lt_cnt_nxt;
				le_cnt_q   <= le_cnt_nxt;
				scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_end) begin
					cand_idx_q <= cand_idx_q + 1'b1;
					if (found) begin
						median_q <= cand_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign median = median_q;

endmodule

// ----- hdl/sliding_median_distance_filter.sv -----
// ----------------------------------------------------------------------------
// sliding_median_distance_filter
// Median filter over the last WINDOW valid range samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one distance sample per item, timeout flag in
//   tuser. Output stream (m_axis_*): one result per input item with the last
//   accepted distance, the window median and the timeout status in tuser.
//   cfg_wr_en/cfg_wr_data set sensor_ready; write it only while idle.
//   While sensor_ready is clear, or an item is flagged as timed out, the
//   window is left untouched and the status reads 1.
// Sequencing:
//   The window is updated on the accept edge; then the median sequencer
//   ranks candidate entries one at a time, each rank pass loading the
//   candidate and comparing it against every window entry on the shared
//   comparator. One item is in flight at a time; s_axis_tready is low
//   until the result enters the output register.
// Reset and stall:
//   Reset fills the window and last distance with 8190 and clears
//   sensor_ready. A result waits in the output register while m_axis_tready
//   is low; the sequencer holds its result until the register frees up.
// ----------------------------------------------------------------------------
module sliding_median_distance_filter #(
	parameter int unsigned WINDOW = smdf_pkg::WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,     // sensor_ready
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // [12:0] distance_sample
	input  logic        s_axis_tuser,    // sample_timed_out
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,    // [12:0] last_distance, [25:13] median_distance
	output logic        m_axis_tuser     // timeout_status
);

	localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned DW    = smdf_pkg::DIST_W;

	logic                sensor_ready_q;
	logic                busy_q;
	logic                status_q;
	logic                out_valid_q;
	logic [DW-1:0]       out_last_q;
	logic [DW-1:0]       out_median_q;
	logic                out_status_q;

	logic                accept;
	logic                win_wr;
	logic                load_out;
	logic [IDX_W-1:0]    rd_addr;
	logic [DW-1:0]       rd_data;
	logic [DW-1:0]       latest;
	logic                med_done;
	logic [DW-1:0]       median;
	smdf_pkg::med_ctrl_t med_ctrl;

	// handshake and control
	assign s_axis_tready  = !busy_q;
	assign accept         = s_axis_tvalid && !busy_q;
	assign win_wr         = accept && sensor_ready_q && !s_axis_tuser;
	assign load_out       = med_done && (!out_valid_q || m_axis_tready);
	assign med_ctrl.start = accept;
	assign med_ctrl.ack   = load_out;

	// config register, busy flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_ready_q <= 1'b0;
			busy_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sensor_ready_q <= cfg_wr_data;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load_out) begin
				busy_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item status and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= !sensor_ready_q || s_axis_tuser;
		end
		if (load_out) begin
			out_last_q   <= latest;
			out_median_q <= median;
			out_status_q <= status_q;
		end
	end

	smdf_window #(
		.WINDOW(WINDOW)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (win_wr),
		.wr_data (s_axis_tdata[DW-1:0]),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.latest  (latest)
	);

	smdf_median #(
		.WINDOW(WINDOW)
	) u_median (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (med_ctrl),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.done    (med_done),
		.median  (median)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_median_q, out_last_q};
	assign m_axis_tuser  = out_status_q;

endmodule
